[design/sptc_pkg.sv]
package sptc_pkg;

	// Field widths fixed by the stream format.
	localparam int RANGE_BITS  = 24;
	localparam int IDX_BITS    = 12;
	localparam int ANG_BITS    = 32;
	localparam int MAX_SAMPLES = 4096;

	// Beat layouts, padded to whole bytes.
	localparam int IN_TDATA_BITS  = ((RANGE_BITS + IDX_BITS + 7) / 8) * 8;
	localparam int COORD_BITS     = RANGE_BITS + 1;
	localparam int OUT_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 32;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LO    = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HI    = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_START = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_STEP  = 8'd3;

	// CORDIC constants: unit vector in Q30, angles at 2^32 per turn.
	localparam int CORDIC_STEPS = 30;
	localparam int UNIT_SHIFT   = 30;
	localparam int UNIT_BITS    = 32;
	localparam int ZW           = ANG_BITS + 1;
	localparam logic signed [UNIT_BITS-1:0] CORDIC_GAIN_INV = 32'sd652032874;
	localparam logic [ANG_BITS-1:0] ARC_TABLE [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// Queue between the front and the back.
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [RANGE_BITS-1:0] range_lo;
		logic [RANGE_BITS-1:0] range_hi;
		logic [ANG_BITS-1:0]   angle_start;
		logic [ANG_BITS-1:0]   angle_step;
	} cfg_t;

	// One accepted sample on its way to the converter.
	typedef struct packed {
		logic [RANGE_BITS-1:0] range_value;
		logic [ANG_BITS-1:0]   angle;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

[design/sptc_front.sv]
module sptc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sptc_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sptc_pkg::RANGE_BITS-1:0] in_range,
	input  logic [sptc_pkg::IDX_BITS-1:0]   in_index,
	input  sptc_pkg::fifo_stat_t           stat,
	output logic                           push,
	output sptc_pkg::work_t                push_data
);
	import sptc_pkg::*;

	logic                  adv;
	logic                  keep;
	logic                  valid_s1;
	logic [RANGE_BITS-1:0] range_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic                  valid_s2;
	logic [RANGE_BITS-1:0] range_s2;
	logic [ANG_BITS-1:0]   prod_s2;

	// The front moves as a whole unless a kept sample waits on a full queue.
	assign adv      = !(valid_s2 && stat.full);
	assign in_ready = adv;

	// A kept sample has a nonzero range inside the bounds and an index inside the scan.
	assign keep = (range_s1 != '0) && (range_s1 >= cfg.range_lo) &&
		(range_s1 <= cfg.range_hi) && (32'(idx_s1) < 32'(MAX_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && keep;
		end
	end

	// Payload: register the beat, then the index times the step.
	always_ff @(posedge clk) begin
		if (adv) begin
			range_s1 <= in_range;
			idx_s1   <= in_index;
			range_s2 <= range_s1;
			prod_s2  <= ANG_BITS'(ANG_BITS'(idx_s1) * cfg.angle_step);
		end
	end

	// The angle wraps modulo one turn.
	assign push                  = valid_s2 && !stat.full;
	assign push_data.range_value = range_s2;
	assign push_data.angle       = cfg.angle_start + prod_s2;

endmodule

[design/sptc_fifo.sv]
module sptc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sptc_pkg::work_t      push_data,
	input  logic                 pop,
	output sptc_pkg::work_t      pop_data,
	output sptc_pkg::fifo_stat_t stat
);
	import sptc_pkg::*;

	work_t                    mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_PTR_BITS:0]   count_q;

	assign stat.full  = (count_q == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[design/sptc_back.sv]
module sptc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sptc_pkg::fifo_stat_t            stat,
	output logic                            pop,
	input  sptc_pkg::work_t                 pop_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sptc_pkg::COORD_BITS-1:0] out_x,
	output logic [sptc_pkg::COORD_BITS-1:0] out_y
);
	import sptc_pkg::*;

	localparam int PW = COORD_BITS + UNIT_BITS;
	localparam int UW = PW - 1;
	localparam int QW = PW - UNIT_SHIFT;
	localparam logic [PW-1:0] HALF = PW'(1) << (UNIT_SHIFT - 1);
	localparam logic [QW-1:0] LIM  = QW'((64'(1) << RANGE_BITS) - 1);

	logic adv;
	logic flip_in;
	logic [ANG_BITS-1:0] folded;

	// CORDIC pipeline, one rotation per stage.
	logic                        v_s [CORDIC_STEPS+1];
	logic                        f_s [CORDIC_STEPS+1];
	logic [RANGE_BITS-1:0]       r_s [CORDIC_STEPS+1];
	logic signed [UNIT_BITS-1:0] x_s [CORDIC_STEPS+1];
	logic signed [UNIT_BITS-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0]        z_s [CORDIC_STEPS];

	logic                 valid_m1, flip_m1;
	logic signed [PW-1:0] px_m1, py_m1;
	logic                 valid_m2, negx_m2, negy_m2;
	logic [UW-1:0]        mx_m2, my_m2;
	logic                 valid_m3, negx_m3, negy_m3;
	logic [QW-1:0]        qx_m3, qy_m3;
	logic [PW-1:0]        sx, sy;
	logic [QW-1:0]        tx, ty;
	logic                 valid_q;
	logic [COORD_BITS-1:0] x_q, y_q;

	// The whole back moves while the output register is free or being taken.
	assign adv       = !valid_q || out_ready;
	assign pop       = adv && !stat.empty;
	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;

	// Fold the angle into the quarter turns around zero.
	assign flip_in = pop_data.angle[ANG_BITS-1] ^ pop_data.angle[ANG_BITS-2];
	assign folded  = {pop_data.angle[ANG_BITS-1] ^ flip_in, pop_data.angle[ANG_BITS-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s[0] <= flip_in;
			r_s[0] <= pop_data.range_value;
			x_s[0] <= CORDIC_GAIN_INV;
			y_s[0] <= '0;
			z_s[0] <= $signed({folded[ANG_BITS-1], folded});
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end

		// Rotate toward the residual angle; shifts round toward minus infinity.
		always_ff @(posedge clk) begin
			if (adv) begin
				f_s[i+1] <= f_s[i];
				r_s[i+1] <= r_s[i];
				if (z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				end
			end
		end

		if (i < CORDIC_STEPS - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (adv) begin
					if (z_s[i][ZW-1]) begin
						z_s[i+1] <= z_s[i] + $signed({1'b0, ARC_TABLE[i]});
					end else begin
						z_s[i+1] <= z_s[i] - $signed({1'b0, ARC_TABLE[i]});
					end
				end
			end
		end
	end

	// Rounding: add half to the magnitude, drop the fraction, clamp.
	assign sx = {1'b0, mx_m2} + HALF;
	assign sy = {1'b0, my_m2} + HALF;
	assign tx = QW'(sx >> UNIT_SHIFT);
	assign ty = QW'(sy >> UNIT_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m1 <= 1'b0;
			valid_m2 <= 1'b0;
			valid_m3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_m1 <= v_s[CORDIC_STEPS];
			valid_m2 <= valid_m1;
			valid_m3 <= valid_m2;
			valid_q  <= valid_m3;
		end
	end

	// Scale, take the magnitude, round and saturate, then restore the sign.
	always_ff @(posedge clk) begin
		if (adv) begin
			flip_m1 <= f_s[CORDIC_STEPS];
			px_m1   <= $signed({1'b0, r_s[CORDIC_STEPS]}) * x_s[CORDIC_STEPS];
			py_m1   <= $signed({1'b0, r_s[CORDIC_STEPS]}) * y_s[CORDIC_STEPS];

			negx_m2 <= px_m1[PW-1] ^ flip_m1;
			negy_m2 <= py_m1[PW-1] ^ flip_m1;
			mx_m2   <= UW'(px_m1[PW-1] ? -px_m1 : px_m1);
			my_m2   <= UW'(py_m1[PW-1] ? -py_m1 : py_m1);

			negx_m3 <= negx_m2;
			negy_m3 <= negy_m2;
			qx_m3   <= (tx > LIM) ? LIM : tx;
			qy_m3   <= (ty > LIM) ? LIM : ty;

			x_q <= negx_m3 ? COORD_BITS'(-qx_m3) : COORD_BITS'(qx_m3);
			y_q <= negy_m3 ? COORD_BITS'(-qy_m3) : COORD_BITS'(qy_m3);
		end
	end

endmodule

[design/scan_polar_to_cartesian.sv]
// Converts lidar range samples to Cartesian points. Each input beat carries a range and
// the sample's index in the scan; a sample whose range is nonzero and lies between the
// low and high range bounds, both included, gives one output beat with x = range*cos and
// y = range*sin, where the angle is angle_start + index*angle_step at 2^32 per turn; other
// samples give nothing. The block takes one beat per cycle while the output is taken, since
// every stage, including the fully pipelined 30-stage CORDIC in the back end, then takes a
// new sample each cycle. A point passes the second front stage, the four-entry queue and
// 35 back stages (angle fold, 30 rotations, scaling product, magnitude, rounding with
// saturation, output register) after the edge that accepts its sample. When the output is
// not taken the back end holds and the front keeps filling the queue. Configuration writes
// are always accepted and must be made while no sample is in flight.
module scan_polar_to_cartesian (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// range_value [23:0], sample_index [35:24], zero padding
	input  logic [sptc_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// point_x [24:0], point_y [49:25], zero padding
	output logic [sptc_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sptc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sptc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import sptc_pkg::*;

	cfg_t       cfg_q;
	fifo_stat_t stat;
	logic       push, pop;
	work_t      push_data, pop_data;
	logic [COORD_BITS-1:0] point_x, point_y;

	// Register file.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_lo    <= '0;
			cfg_q.range_hi    <= '1;
			cfg_q.angle_start <= '0;
			cfg_q.angle_step  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RANGE_LO:    cfg_q.range_lo    <= cfg_data[RANGE_BITS-1:0];
				REG_RANGE_HI:    cfg_q.range_hi    <= cfg_data[RANGE_BITS-1:0];
				REG_ANGLE_START: cfg_q.angle_start <= cfg_data[ANG_BITS-1:0];
				REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data[ANG_BITS-1:0];
				default: ;
			endcase
		end
	end

	sptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_range  (s_tdata[RANGE_BITS-1:0]),
		.in_index  (s_tdata[RANGE_BITS +: IDX_BITS]),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	sptc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	sptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_x     (point_x),
		.out_y     (point_y)
	);

	assign m_tdata = OUT_TDATA_BITS'({point_y, point_x});

endmodule

[design/sptc_checker.sv]
module sptc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [sptc_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
	import sptc_pkg::*;

	// A stalled output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat withdrawn while stalled");

	// A stalled output beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output payload changed while stalled");

	// Saturation is symmetric, so the most negative code never shows on x.
	a_x_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[COORD_BITS-1:0] != {1'b1, {RANGE_BITS{1'b0}}})
		else $error("point_x outside saturation limit");

	// Likewise for y.
	a_y_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2*COORD_BITS-1:COORD_BITS] != {1'b1, {RANGE_BITS{1'b0}}})
		else $error("point_y outside saturation limit");

endmodule

bind scan_polar_to_cartesian sptc_checker u_checker (.*);
